// ===== hdl/ist_pkg.sv =====
// Shared types, constants and codes for the interval set table.
package ist_pkg;

  localparam int CAPACITY  = 64;
  localparam int TIME_BITS = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic [TIME_BITS-1:0] tick_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [1:0]           status_t;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_ERASE    = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_BOUNDS   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_WRNEW,
    S_BND0,
    S_BND1,
    S_BND2,
    S_RESP
  } seq_state_t;

  // One stored range, begin in the low half.
  typedef struct packed {
    tick_t stop;
    tick_t start;
  } entry_t;

  // Memory port controls driven by the sequencer.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
  } mem_ctl_t;

  typedef struct packed {
    status_t status;
    logic    hit;
    tick_t   rb;
    tick_t   re;
    cnt_t    count;
  } result_t;

endpackage

// ===== hdl/ist_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module ist_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ist_seq.sv =====
// Operation sequencer: scans the sorted table and, for insert and erase, shifts and rewrites it.
module ist_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  ist_pkg::op_t      op,
  input  ist_pkg::tick_t    b_in,
  input  ist_pkg::tick_t    e_in,
  output logic              ready,
  output logic              res_valid,
  input  logic              res_ready,
  output ist_pkg::result_t  res,
  output ist_pkg::mem_ctl_t mem_ctl,
  output ist_pkg::entry_t   wr_data,
  input  ist_pkg::entry_t   rd_data
);
  import ist_pkg::*;

  seq_state_t state_r, state_nxt;
  op_t     op_r, op_nxt;
  tick_t   b_r, b_nxt, e_r, e_nxt;
  cnt_t    cnt_r, cnt_nxt;
  cnt_t    idx_r, idx_nxt;
  logic    sv_r, sv_nxt;
  cnt_t    si_r, si_nxt;
  logic    qf_r, qf_nxt;
  cnt_t    qi_r, qi_nxt;
  tick_t   qs_r, qs_nxt, qt_r, qt_nxt;
  logic    past_r, past_nxt;
  logic    stop_r, stop_nxt;
  logic    lq_r, lq_nxt;
  logic    cov_r, cov_nxt;
  cnt_t    lo_r, lo_nxt, hi_r, hi_nxt;
  tick_t   ext_r, ext_nxt;
  logic [1:0] n_r, n_nxt;
  entry_t  new0_r, new0_nxt, new1_r, new1_nxt;
  cnt_t    left_r, left_nxt;
  logic    up_r, up_nxt;
  logic    mv_v_r, mv_v_nxt;
  cnt_t    mv_src_r, mv_src_nxt;
  logic    wn_r, wn_nxt;
  status_t st_r, st_nxt;
  logic    hit_r, hit_nxt;
  tick_t   rb_r, rb_nxt, re_r, re_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sv_r    <= 1'b0;
      mv_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sv_r    <= sv_nxt;
      mv_v_r  <= mv_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    b_r      <= b_nxt;
    e_r      <= e_nxt;
    idx_r    <= idx_nxt;
    si_r     <= si_nxt;
    qf_r     <= qf_nxt;
    qi_r     <= qi_nxt;
    qs_r     <= qs_nxt;
    qt_r     <= qt_nxt;
    past_r   <= past_nxt;
    stop_r   <= stop_nxt;
    lq_r     <= lq_nxt;
    cov_r    <= cov_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    ext_r    <= ext_nxt;
    n_r      <= n_nxt;
    new0_r   <= new0_nxt;
    new1_r   <= new1_nxt;
    left_r   <= left_nxt;
    up_r     <= up_nxt;
    mv_src_r <= mv_src_nxt;
    wn_r     <= wn_nxt;
    st_r     <= st_nxt;
    hit_r    <= hit_nxt;
    rb_r     <= rb_nxt;
    re_r     <= re_nxt;
  end

  always_comb begin
    cnt_t  p;
    logic  i_lq, i_cov;
    cnt_t  i_lo, i_hi;
    tick_t i_ext;
    logic  c_lq, c_cov, c_stop;
    cnt_t  c_lo, c_hi, span;
    tick_t c_ext;
    logic  left_cut, right_cut;
    logic [1:0] n_new;
    logic [CNT_W:0] ncnt;

    state_nxt  = state_r;
    op_nxt     = op_r;
    b_nxt      = b_r;
    e_nxt      = e_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    sv_nxt     = 1'b0;
    si_nxt     = si_r;
    qf_nxt     = qf_r;
    qi_nxt     = qi_r;
    qs_nxt     = qs_r;
    qt_nxt     = qt_r;
    past_nxt   = past_r;
    stop_nxt   = stop_r;
    lq_nxt     = lq_r;
    cov_nxt    = cov_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    ext_nxt    = ext_r;
    n_nxt      = n_r;
    new0_nxt   = new0_r;
    new1_nxt   = new1_r;
    left_nxt   = left_r;
    up_nxt     = up_r;
    mv_v_nxt   = 1'b0;
    mv_src_nxt = mv_src_r;
    wn_nxt     = wn_r;
    st_nxt     = st_r;
    hit_nxt    = hit_r;
    rb_nxt     = rb_r;
    re_nxt     = re_r;
    ready      = 1'b0;
    res_valid  = 1'b0;
    mem_ctl    = '0;
    wr_data    = new0_r;

    // Starting point of the merge or cut run, given the first index p
    // whose begin lies above the request begin.
    p = (state_r == S_DECIDE) ? cnt_r : si_r;
    if (op_r == OP_INSERT) begin
      i_cov = qf_r && (qt_r >= e_r);
      i_lq  = qf_r && (qt_r >= b_r);
      i_ext = e_r;
    end else begin
      i_cov = 1'b0;
      i_lq  = qf_r && (qt_r > b_r);
      i_ext = qt_r;
    end
    i_lo = i_lq ? qi_r : p;
    i_hi = i_lq ? qi_r + cnt_t'(1) : p;

    c_lq   = past_r ? lq_r   : i_lq;
    c_cov  = past_r ? cov_r  : i_cov;
    c_lo   = past_r ? lo_r   : i_lo;
    c_hi   = past_r ? hi_r   : i_hi;
    c_ext  = past_r ? ext_r  : i_ext;
    c_stop = past_r ? stop_r : i_cov;
    span   = c_hi - c_lo;
    left_cut  = c_lq && (qs_r < b_r);
    right_cut = c_ext > e_r;
    n_new     = {1'b0, left_cut} + {1'b0, right_cut};
    ncnt      = {1'b0, cnt_r} - {1'b0, span} + (CNT_W+1)'(n_new);

    case (state_r)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          op_nxt   = op;
          b_nxt    = b_in;
          e_nxt    = e_in;
          idx_nxt  = '0;
          qf_nxt   = 1'b0;
          past_nxt = 1'b0;
          stop_nxt = 1'b0;
          st_nxt   = ST_DONE;
          hit_nxt  = 1'b0;
          rb_nxt   = '0;
          re_nxt   = '0;
          if ((op == OP_INSERT || op == OP_ERASE) && b_in >= e_in) begin
            st_nxt    = ST_EMPTY;
            state_nxt = S_RESP;
          end else if (op == OP_BOUNDS) begin
            state_nxt = S_BND0;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (idx_r < cnt_r) begin
          mem_ctl.rd_en   = 1'b1;
          mem_ctl.rd_addr = idx_r[ADDR_W-1:0];
          idx_nxt         = idx_r + cnt_t'(1);
          sv_nxt          = 1'b1;
          si_nxt          = idx_r;
        end else if (!sv_r) begin
          state_nxt = S_DECIDE;
        end
        if (sv_r) begin
          if (!past_r && rd_data.start <= b_r) begin
            qf_nxt = 1'b1;
            qi_nxt = si_r;
            qs_nxt = rd_data.start;
            qt_nxt = rd_data.stop;
          end else begin
            past_nxt = 1'b1;
            lq_nxt   = c_lq;
            cov_nxt  = c_cov;
            lo_nxt   = c_lo;
            hi_nxt   = c_hi;
            ext_nxt  = c_ext;
            stop_nxt = c_stop;
            if (!c_stop) begin
              if (op_r == OP_INSERT) begin
                if (rd_data.start <= c_ext) begin
                  if (rd_data.stop > c_ext) begin
                    ext_nxt = rd_data.stop;
                  end
                  hi_nxt = si_r + cnt_t'(1);
                end else begin
                  stop_nxt = 1'b1;
                end
              end else begin
                if (rd_data.start < e_r) begin
                  ext_nxt = rd_data.stop;
                  hi_nxt  = si_r + cnt_t'(1);
                end else begin
                  stop_nxt = 1'b1;
                end
              end
            end
          end
        end
      end

      S_DECIDE: begin
        state_nxt = S_RESP;
        lo_nxt    = c_lo;
        hi_nxt    = c_hi;
        left_nxt  = cnt_r - c_hi;
        wn_nxt    = 1'b0;
        case (op_r)
          OP_CONTAINS: begin
            hit_nxt = qf_r && (qt_r > b_r);
          end
          OP_INSERT: begin
            if (c_cov) begin
              rb_nxt = qs_r;
              re_nxt = qt_r;
            end else if (span == '0 && cnt_r >= cnt_t'(CAPACITY)) begin
              st_nxt = ST_FULL;
            end else begin
              n_nxt          = 2'd1;
              new0_nxt.start = c_lq ? qs_r : b_r;
              new0_nxt.stop  = c_ext;
              rb_nxt         = c_lq ? qs_r : b_r;
              re_nxt         = c_ext;
              up_nxt         = (span == '0);
              idx_nxt        = (span == '0) ? cnt_r - cnt_t'(1) : c_hi;
              state_nxt      = S_MOVE;
            end
          end
          OP_ERASE: begin
            if (span != '0) begin
              if (ncnt > (CNT_W+1)'(CAPACITY)) begin
                st_nxt = ST_FULL;
              end else begin
                n_nxt          = n_new;
                new0_nxt.start = left_cut ? qs_r : e_r;
                new0_nxt.stop  = left_cut ? b_r : c_ext;
                new1_nxt.start = e_r;
                new1_nxt.stop  = c_ext;
                up_nxt         = ({1'b0, n_new} > {1'b0, span});
                idx_nxt        = ({1'b0, n_new} > {1'b0, span}) ?
                                 cnt_r - cnt_t'(1) : c_hi;
                state_nxt      = S_MOVE;
              end
            end
          end
          default: begin
          end
        endcase
      end

      S_MOVE: begin
        // Reads run one entry ahead of the writes; the direction keeps
        // every write clear of entries not yet read.
        if (left_r != '0) begin
          mem_ctl.rd_en   = 1'b1;
          mem_ctl.rd_addr = idx_r[ADDR_W-1:0];
          idx_nxt         = up_r ? idx_r - cnt_t'(1) : idx_r + cnt_t'(1);
          left_nxt        = left_r - cnt_t'(1);
          mv_v_nxt        = 1'b1;
          mv_src_nxt      = idx_r;
        end else if (!mv_v_r) begin
          state_nxt = S_WRNEW;
        end
        if (mv_v_r) begin
          mem_ctl.wr_en   = 1'b1;
          mem_ctl.wr_addr = ADDR_W'(mv_src_r - hi_r + lo_r + cnt_t'(n_r));
          wr_data         = rd_data;
        end
      end

      S_WRNEW: begin
        if (n_r != 2'd0) begin
          mem_ctl.wr_en   = 1'b1;
          mem_ctl.wr_addr = ADDR_W'(lo_r + cnt_t'(wn_r));
          wr_data         = wn_r ? new1_r : new0_r;
        end
        if (n_r == 2'd0 || {1'b0, wn_r} == n_r - 2'd1) begin
          cnt_nxt   = cnt_r - (hi_r - lo_r) + cnt_t'(n_r);
          state_nxt = S_RESP;
        end else begin
          wn_nxt = 1'b1;
        end
      end

      S_BND0: begin
        if (cnt_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          mem_ctl.rd_en   = 1'b1;
          mem_ctl.rd_addr = '0;
          state_nxt       = S_BND1;
        end
      end

      S_BND1: begin
        mem_ctl.rd_en   = 1'b1;
        mem_ctl.rd_addr = ADDR_W'(cnt_r - cnt_t'(1));
        rb_nxt          = rd_data.start;
        state_nxt       = S_BND2;
      end

      S_BND2: begin
        re_nxt    = rd_data.stop;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status = st_r;
  assign res.hit    = hit_r;
  assign res.rb     = rb_r;
  assign res.re     = re_r;
  assign res.count  = cnt_r;

endmodule

// ===== hdl/interval_set_table.sv =====
// Top level of the interval set table: stream ports, sequencer, range RAM.
//
//   channel  | dir | tdata (low bit up)                              | tuser
//   ---------+-----+-------------------------------------------------+--------
//   in_      | in  | range_begin[31:0], range_end[63:32]             | op
//   out_     | out | hit[0], result_begin[32:1], result_end[64:33],  | status
//            |     | entry_count[71:65]                              |
//
// One request is worked on at a time. Contains and insert/erase scan the
// stored ranges one entry a cycle through the single RAM read port; insert
// and erase then move every entry behind the touched run, one a cycle, and
// write up to two new ones. Bounds reads only the first and last entries.
// Reset clears the stored count and the control state; the RAM contents
// are never cleared, since entries at or above the count are never read.
// A stalled result sits in the output register while the next request is
// already taken in and worked on.
module interval_set_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // range_begin, range_end
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // hit, result_begin, result_end, entry_count
  output logic [1:0]  out_tuser   // status
);
  import ist_pkg::*;

  logic      seq_ready;
  logic      res_valid;
  logic      res_ready;
  result_t   res;
  mem_ctl_t  mem_ctl;
  entry_t    wr_data;
  entry_t    rd_data;

  logic        out_tvalid_r, out_tvalid_nxt;
  logic [71:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  // The sequencer takes a new request only while it is idle.
  assign in_tready = seq_ready;

  ist_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && seq_ready),
    .op        (op_t'(in_tuser)),
    .b_in      (in_tdata[TIME_BITS-1:0]),
    .e_in      (in_tdata[2*TIME_BITS-1:TIME_BITS]),
    .ready     (seq_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_ctl   (mem_ctl),
    .wr_data   (wr_data),
    .rd_data   (rd_data)
  );

  ist_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk     (clk),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (mem_ctl.rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_ctl.wr_en),
    .wr_addr (mem_ctl.wr_addr),
    .wr_data (wr_data)
  );

  // Output register: loads a finished result whenever it is empty or being
  // drained in the same cycle.
  assign res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid && res_ready) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_tdata_r <= {res.count, res.re, res.rb, res.hit};
      out_tuser_r <= res.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== hdl/ist_checker.sv =====
// Port-level checks for the interval set table, bound to the top level.
module ist_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import ist_pkg::*;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_DONE || out_tuser == ST_EMPTY ||
                    out_tuser == ST_FULL))
    else $error("result status carries an unused code");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[71:65] <= 7'(CAPACITY)))
    else $error("entry count above capacity");

  a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tuser == ST_DONE))
    else $error("hit reported with a non-done status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_FULL)) |->
      (out_tdata[64:0] == '0))
    else $error("ignored or rejected request reports a range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result dropped or changed");

endmodule

bind interval_set_table ist_checker u_ist_checker (.*);
